@@ rtl/k33_free_triple_tracker_defines.svh @@
// Assertion helpers for the triple tracker.
`ifndef K33_FREE_TRIPLE_TRACKER_DEFINES_SVH
`define K33_FREE_TRIPLE_TRACKER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define K33_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define K33_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/k33_pkg.sv @@
package k33_pkg;

    localparam int MAX_COLS   = 24;
    localparam int ROW_W      = MAX_COLS;
    localparam int NCOL_W     = 5;
    localparam int MODE_W     = 2;
    localparam int COL_W      = $clog2(MAX_COLS + 1);
    localparam int PAIR_DEPTH = MAX_COLS * MAX_COLS;
    localparam int ADDR_W     = $clog2(PAIR_DEPTH);
    localparam int WORD_W     = 2 * ROW_W;

    localparam logic [MODE_W-1:0] MODE_TEST     = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_COMMIT   = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_UNCOMMIT = MODE_W'(2);

    localparam logic [NCOL_W-1:0] NCOL_RESET = NCOL_W'(24);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_CHECK_DRAIN,
        ST_DECIDE,
        ST_UPDATE,
        ST_UPDATE_DRAIN,
        ST_REPORT
    } k33_state_t;

    typedef struct packed {
        logic clear_en;
        logic load;
        logic cursor_init;
        logic scan;
        logic upd_pass;
    } k33_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_done;
        logic need_update;
    } k33_status_t;

endpackage

@@ rtl/k33_ctrl.sv @@
module k33_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    output k33_pkg::k33_cmd_t     cmd,
    input  k33_pkg::k33_status_t  status
);
    import k33_pkg::*;

    k33_state_t state_reg;
    k33_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_CHECK_DRAIN;
                end
            end
            ST_CHECK_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = status.need_update ? ST_UPDATE : ST_REPORT;
            end
            ST_UPDATE:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_UPDATE_DRAIN;
                end
            end
            ST_UPDATE_DRAIN:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            ST_IDLE:
            begin
                busy            = 1'b0;
                cmd.load        = start;
                cmd.cursor_init = start;
            end
            ST_CHECK:
            begin
                cmd.scan = 1'b1;
            end
            ST_CHECK_DRAIN:
            begin
                // check verdict already settled; rewind cursor for the update pass
                cmd.cursor_init = 1'b1;
            end
            ST_DECIDE:
            begin
                cmd = '0;
            end
            ST_UPDATE:
            begin
                cmd.scan     = 1'b1;
                cmd.upd_pass = 1'b1;
            end
            ST_UPDATE_DRAIN:
            begin
                cmd = '0;
            end
            ST_REPORT:
            begin
                done = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/k33_dpath.sv @@
module k33_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [k33_pkg::NCOL_W-1:0]   cfg_data,
    input  logic [k33_pkg::MODE_W-1:0]   mode,
    input  logic [k33_pkg::ROW_W-1:0]    row_mask,
    input  k33_pkg::k33_cmd_t            cmd,
    output k33_pkg::k33_status_t         status,
    output logic                         legal,
    output logic                         applied
);
    import k33_pkg::*;

    function automatic logic [COL_W-1:0] eff_cols(input logic [NCOL_W-1:0] num);
        logic [COL_W-1:0] res;
        if (int'(num) < 3)
        begin
            res = COL_W'(3);
        end
        else if (int'(num) > MAX_COLS)
        begin
            res = COL_W'(MAX_COLS);
        end
        else
        begin
            res = COL_W'(num);
        end
        return res;
    endfunction

    // column c sits at bit n-1-c
    function automatic logic [ROW_W-1:0] col_bit(input logic [COL_W-1:0] n,
                                                 input logic [COL_W-1:0] c);
        logic [COL_W-1:0] pos;
        pos = n - COL_W'(1) - c;
        return ROW_W'(1) << pos;
    endfunction

    logic [WORD_W-1:0]  pair_mem [PAIR_DEPTH];

    logic [NCOL_W-1:0]  ncol_reg, ncol_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   a_reg, a_next;
    logic [COL_W-1:0]   b_reg, b_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               pend_upd_reg, pend_upd_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [ROW_W-1:0]   pend_rest_reg, pend_rest_next;
    logic               legal_reg, legal_next;
    logic               applied_reg, applied_next;
    logic [WORD_W-1:0]  rd_data_reg;

    logic [COL_W-1:0]   n;
    logic [ROW_W-1:0]   low_mask;
    logic [ROW_W-1:0]   bit_a_mask, bit_b_mask;
    logic               bit_a, bit_b;
    logic               scan_done;
    logic               issue;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ROW_W-1:0]   word_once, word_twice;
    logic [ROW_W-1:0]   new_once, new_twice;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;

    assign n = eff_cols(ncol_reg);

    always_comb
    begin
        for (int i = 0; i < ROW_W; i++)
        begin
            low_mask[i] = (i < int'(n));
        end
    end

    // pair cursor: walks a<b<n, skipping a whole row of b when column a is absent
    assign bit_a_mask = col_bit(n, a_reg);
    assign bit_b_mask = col_bit(n, b_reg);
    assign bit_a      = |(row_reg & bit_a_mask);
    assign bit_b      = |(row_reg & bit_b_mask);
    assign scan_done  = (a_reg >= n - COL_W'(1));
    assign issue      = cmd.scan && !scan_done && bit_a && bit_b;
    assign rd_addr    = ADDR_W'(a_reg) * ADDR_W'(MAX_COLS) + ADDR_W'(b_reg);

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        if (cmd.cursor_init)
        begin
            a_next = '0;
            b_next = COL_W'(1);
        end
        else if (cmd.scan && !scan_done)
        begin
            if (!bit_a || (b_reg == n - COL_W'(1)))
            begin
                a_next = a_reg + COL_W'(1);
                b_next = a_reg + COL_W'(2);
            end
            else
            begin
                b_next = b_reg + COL_W'(1);
            end
        end
    end

    assign pend_valid_next = issue;
    assign pend_upd_next   = cmd.upd_pass;
    assign pend_addr_next  = rd_addr;
    assign pend_rest_next  = row_reg & ~bit_a_mask & ~bit_b_mask;

    // second stage: read data back, evaluate, and write back in the update pass
    assign word_once  = rd_data_reg[ROW_W-1:0];
    assign word_twice = rd_data_reg[WORD_W-1:ROW_W];

    always_comb
    begin
        new_once = word_once ^ pend_rest_reg;
        if (mode_reg == MODE_COMMIT)
        begin
            new_twice = word_twice | (word_once & pend_rest_reg);
        end
        else
        begin
            new_twice = word_twice & ~(new_once & pend_rest_reg);
        end
    end

    assign wr_en   = cmd.clear_en || (pend_valid_reg && pend_upd_reg);
    assign wr_addr = cmd.clear_en ? clr_addr_reg : pend_addr_reg;
    assign wr_data = cmd.clear_en ? '0 : {new_twice, new_once};

    assign clr_addr_next = cmd.clear_en ? clr_addr_reg + ADDR_W'(1) : clr_addr_reg;

    always_comb
    begin
        legal_next = legal_reg;
        if (cmd.load)
        begin
            legal_next = 1'b1;
        end
        else if (pend_valid_reg && !pend_upd_reg && (|(row_reg & word_twice)))
        begin
            legal_next = 1'b0;
        end
    end

    always_comb
    begin
        applied_next = applied_reg;
        if (cmd.load)
        begin
            applied_next = 1'b0;
        end
        else if (pend_valid_reg && pend_upd_reg &&
                 ((new_once != word_once) || (new_twice != word_twice)))
        begin
            applied_next = 1'b1;
        end
    end

    assign ncol_next = cfg_we ? cfg_data : ncol_reg;
    assign mode_next = cmd.load ? mode : mode_reg;
    assign row_next  = cmd.load ? (row_mask & low_mask) : row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncol_reg       <= NCOL_RESET;
            a_reg          <= '0;
            b_reg          <= '0;
            clr_addr_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_upd_reg   <= 1'b0;
            legal_reg      <= 1'b1;
            applied_reg    <= 1'b0;
        end
        else
        begin
            ncol_reg       <= ncol_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            clr_addr_reg   <= clr_addr_next;
            pend_valid_reg <= pend_valid_next;
            pend_upd_reg   <= pend_upd_next;
            legal_reg      <= legal_next;
            applied_reg    <= applied_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        row_reg       <= row_next;
        pend_addr_reg <= pend_addr_next;
        pend_rest_reg <= pend_rest_next;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= pair_mem[rd_addr];
        end
        if (wr_en)
        begin
            pair_mem[wr_addr] <= wr_data;
        end
    end

    assign status.clear_last  = (clr_addr_reg == ADDR_W'(PAIR_DEPTH - 1));
    assign status.scan_done   = scan_done;
    assign status.need_update = ((mode_reg == MODE_COMMIT) && legal_reg) ||
                                (mode_reg == MODE_UNCOMMIT);

    assign legal   = legal_reg;
    assign applied = applied_reg;

endmodule

@@ rtl/k33_free_triple_tracker.sv @@
// A test, a refused commit or any other mode walks the pairs once before done; a legal
// commit or an uncommit walks them a second time to update. The pair walk takes one step
// per pair (a,b) of a present column a and one per absent column short of the last; it
// covers at most 276 pairs for 24 columns. One transaction at a time: the next start is
// taken the cycle after done; the strobe cannot stall.
// After reset the pair RAM is zeroed with busy high; config writes still land.
`include "k33_free_triple_tracker_defines.svh"
module k33_free_triple_tracker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [k33_pkg::NCOL_W-1:0]   cfg_data,
    input  logic                         start,
    output logic                         busy,
    input  logic [k33_pkg::MODE_W-1:0]   mode,
    input  logic [k33_pkg::ROW_W-1:0]    row_mask,
    output logic                         done,
    output logic                         legal,
    output logic                         applied
);
    import k33_pkg::*;

    k33_cmd_t    cmd;
    k33_status_t status;

    k33_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    k33_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .mode     (mode),
        .row_mask (row_mask),
        .cmd      (cmd),
        .status   (status),
        .legal    (legal),
        .applied  (applied)
    );

    `K33_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done, "accepted transaction did not go busy")
    `K33_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done && !busy, "result strobe longer than one cycle")
    `K33_ASSERT_SAME(a_done_quiet, clk, rst_n, done, busy && !cmd.scan && !cmd.clear_en, "result while datapath active")
    `K33_ASSERT_SAME(a_clear_idle, clk, rst_n, cmd.clear_en, busy && !cmd.load && !cmd.scan, "transaction during RAM clear")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import k33_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int DRAIN_CYCLES = 600;
    localparam logic [MODE_W-1:0] MODE_SPARE = MODE_W'(3);

    typedef struct packed {
        logic legal;
        logic applied;
    } verdict_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [NCOL_W-1:0]   cfg_data = '0;
    logic                start = 1'b0;
    logic                busy;
    logic [MODE_W-1:0]   mode = MODE_TEST;
    logic [ROW_W-1:0]    row_mask = '0;
    logic                done;
    logic                legal;
    logic                applied;

    // predictor copy of the triple-count store
    bit [ROW_W-1:0]      once_bits [PAIR_DEPTH];
    bit [ROW_W-1:0]      twice_bits [PAIR_DEPTH];
    logic [NCOL_W-1:0]   col_setting = NCOL_RESET;

    verdict_t            pending_verdicts [$];
    int                  cycle_count = 0;
    int                  mismatch_count = 0;
    int                  rows_sent = 0;
    int                  illegal_seen = 0;
    int                  store_updates = 0;
    int                  settings_used = 0;
    bit                  no_gaps = 1'b0;

    k33_free_triple_tracker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .row_mask (row_mask),
        .done     (done),
        .legal    (legal),
        .applied  (applied)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("tb failed");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("cycle %0d: result with nothing pending (legal=%0b applied=%0b)",
                             cycle_count, legal, applied);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (legal !== want.legal || applied !== want.applied)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("cycle %0d: expected legal=%0b applied=%0b, got legal=%0b applied=%0b",
                                 cycle_count, want.legal, want.applied, legal, applied);
                end
            end
        end
    end

    function automatic int active_columns();
        if (col_setting < 3)
            return 3;
        if (col_setting > MAX_COLS)
            return MAX_COLS;
        return int'(col_setting);
    endfunction

    // Judges the row against the store as it stands, then applies a legal commit or an uncommit.
    function automatic verdict_t judge_row(input logic [MODE_W-1:0] m,
                                           input logic [ROW_W-1:0] raw);
        int n;
        int a;
        int b;
        int idx;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] rest;
        logic [ROW_W-1:0] o;
        logic [ROW_W-1:0] t;
        logic [ROW_W-1:0] no;
        logic [ROW_W-1:0] nt;
        verdict_t v;
        n = active_columns();
        row = raw & ROW_W'((64'd1 << n) - 1);
        v.legal = 1'b1;
        v.applied = 1'b0;
        for (a = 0; a < n; a++)
        begin
            for (b = a + 1; b < n; b++)
            begin
                if (row[n-1-a] && row[n-1-b] && (row & twice_bits[a*MAX_COLS+b]) != '0)
                    v.legal = 1'b0;
            end
        end
        if ((m == MODE_COMMIT && v.legal) || m == MODE_UNCOMMIT)
        begin
            for (a = 0; a < n; a++)
            begin
                for (b = a + 1; b < n; b++)
                begin
                    if (row[n-1-a] && row[n-1-b])
                    begin
                        idx = a * MAX_COLS + b;
                        rest = row;
                        rest[n-1-a] = 1'b0;
                        rest[n-1-b] = 1'b0;
                        o = once_bits[idx];
                        t = twice_bits[idx];
                        no = o ^ rest;
                        if (m == MODE_COMMIT)
                            nt = t | (o & rest);
                        else
                            nt = t & ~(no & rest);
                        if (no != o || nt != t)
                            v.applied = 1'b1;
                        once_bits[idx] = no;
                        twice_bits[idx] = nt;
                    end
                end
            end
        end
        return v;
    endfunction

    function automatic logic [ROW_W-1:0] random_columns(input int n, input int count);
        logic [ROW_W-1:0] r;
        r = '0;
        while ($countones(r) < count)
            r[$urandom_range(0, n - 1)] = 1'b1;
        return r;
    endfunction

    // Leaves start high on return so a back-to-back transaction needs no toggle.
    task automatic send_row(input logic [MODE_W-1:0] m, input logic [ROW_W-1:0] r,
                            output verdict_t v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= m;
        row_mask <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        v = judge_row(m, r);
        pending_verdicts.push_back(v);
        rows_sent++;
        if (!v.legal)
            illegal_seen++;
        if (v.applied)
            store_updates++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic apply_columns(input logic [NCOL_W-1:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        col_setting = value;
        settings_used++;
    endtask

    // 24 columns: column c sits at bit 23-c
    task automatic test_directed_rows();
        verdict_t v;
        send_row(MODE_TEST, 24'h000000, v);
        send_row(MODE_TEST, 24'hFFFFFF, v);
        send_row(MODE_COMMIT, 24'h800001, v);      // two columns, no triple
        send_row(MODE_COMMIT, 24'hE00000, v);
        send_row(MODE_COMMIT, 24'hE00000, v);      // count reaches two
        send_row(MODE_COMMIT, 24'hE00000, v);      // refused
        send_row(MODE_TEST, 24'hF00000, v);
        send_row(MODE_SPARE, 24'hE00000, v);
        send_row(MODE_COMMIT, 24'h800003, v);      // first and last two columns
        send_row(MODE_UNCOMMIT, 24'hE00000, v);
        send_row(MODE_UNCOMMIT, 24'hE00000, v);
        send_row(MODE_UNCOMMIT, 24'hE00000, v);    // not committed any more
        send_row(MODE_UNCOMMIT, 24'hE00000, v);
        send_row(MODE_COMMIT, 24'hFFFFFF, v);
        send_row(MODE_COMMIT, 24'hFFFFFF, v);
        send_row(MODE_TEST, 24'h000007, v);
        send_row(MODE_SPARE, 24'hFFFFFF, v);
        send_row(MODE_COMMIT, 24'h000007, v);
        send_row(MODE_UNCOMMIT, 24'hFFFFFF, v);
        send_row(MODE_UNCOMMIT, 24'hFFFFFF, v);
        send_row(MODE_UNCOMMIT, 24'h800003, v);
        send_row(MODE_UNCOMMIT, 24'h000000, v);
        send_row(MODE_TEST, 24'hA5A5A5, v);
        send_row(MODE_TEST, 24'h5A5A5A, v);
    endtask

    // small and out-of-range counts, and remapping with rows still committed
    task automatic test_column_counts();
        verdict_t v;
        apply_columns(NCOL_W'(3));
        send_row(MODE_COMMIT, 24'hFFFFFF, v);      // bits above the count masked
        send_row(MODE_COMMIT, 24'h000007, v);
        send_row(MODE_TEST, 24'hFFFFF8, v);
        send_row(MODE_COMMIT, 24'h000007, v);
        apply_columns(NCOL_W'(0));
        send_row(MODE_TEST, 24'h000007, v);
        send_row(MODE_UNCOMMIT, 24'h000007, v);
        apply_columns(NCOL_W'(1));
        send_row(MODE_TEST, 24'h000005, v);
        send_row(MODE_UNCOMMIT, 24'hFFFFFF, v);
        apply_columns(NCOL_W'(2));
        send_row(MODE_COMMIT, 24'h000003, v);
        send_row(MODE_UNCOMMIT, 24'h000007, v);
        apply_columns(NCOL_W'(24));
        send_row(MODE_COMMIT, 24'hE00000, v);
        send_row(MODE_COMMIT, 24'hE00001, v);
        apply_columns(NCOL_W'(12));
        send_row(MODE_TEST, 24'h000E00, v);
        send_row(MODE_COMMIT, 24'h000E00, v);
        send_row(MODE_COMMIT, 24'hFFFE01, v);
        apply_columns(NCOL_W'(31));
        send_row(MODE_TEST, 24'hE00000, v);
        send_row(MODE_UNCOMMIT, 24'hE00000, v);
        send_row(MODE_UNCOMMIT, 24'hE00001, v);
        apply_columns(NCOL_W'(25));
        send_row(MODE_TEST, 24'hFFFFFF, v);
        apply_columns(NCOL_W'(12));
        send_row(MODE_UNCOMMIT, 24'h000E00, v);
        send_row(MODE_UNCOMMIT, 24'h000E01, v);
        send_row(MODE_SPARE, 24'h000FFF, v);
    endtask

    // mostly small well-formed commit/recommit/uncommit traffic, some noise
    task automatic test_random_traffic();
        logic [ROW_W-1:0] committed [$];
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] keep;
        logic [MODE_W-1:0] m;
        verdict_t v;
        int phase;
        int k;
        int n;
        int pick;
        int slot;
        for (phase = 0; phase < 8; phase++)
        begin
            no_gaps = 1'b0;
            case (phase)
                0: apply_columns(NCOL_W'(24));
                1: apply_columns(NCOL_W'(3));
                2: apply_columns(NCOL_W'(31));
                3: apply_columns(NCOL_W'(0));
                4: apply_columns(NCOL_W'(24));
                default: apply_columns(NCOL_W'($urandom_range(0, 31)));
            endcase
            committed.delete();
            n = active_columns();
            keep = ROW_W'((64'd1 << n) - 1);
            for (k = 0; k < 180; k++)
            begin
                if (k % 40 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                row = random_columns(n, $urandom_range(3, (n < 6) ? n : 6));
                if ($urandom_range(0, 3) == 0)
                    row = row | (ROW_W'($urandom) & ~keep);
                if (pick < 40 || (pick < 70 && committed.size() == 0))
                begin
                    send_row(MODE_COMMIT, row, v);
                    if (v.legal)
                        committed.push_back(row);
                end
                else if (pick < 52)
                begin
                    slot = $urandom_range(0, committed.size() - 1);
                    send_row(MODE_COMMIT, committed[slot], v);
                    if (v.legal)
                        committed.push_back(committed[slot]);
                end
                else if (pick < 70)
                begin
                    slot = $urandom_range(0, committed.size() - 1);
                    send_row(MODE_UNCOMMIT, committed[slot], v);
                    committed.delete(slot);
                end
                else if (pick < 82)
                    send_row(MODE_TEST, row, v);
                else if (pick < 87)
                    send_row(MODE_UNCOMMIT, row, v);
                else if (pick < 90)
                    send_row(MODE_SPARE, row, v);
                else if (pick < 95)
                    send_row(MODE_W'($urandom_range(0, 3)),
                             random_columns(n, $urandom_range(0, 2)), v);
                else
                begin
                    m = MODE_W'($urandom_range(0, 3));
                    row = ROW_W'($urandom);
                    send_row(m, row, v);
                    if (m == MODE_COMMIT && v.legal)
                        committed.push_back(row);
                end
            end
            // odd phases take every committed row back out
            if (phase % 2 == 1)
            begin
                no_gaps = 1'b0;
                while (committed.size() != 0)
                    send_row(MODE_UNCOMMIT, committed.pop_back(), v);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_rows();
        test_column_counts();
        test_random_traffic();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatch_count = mismatch_count + pending_verdicts.size();
        $display("Sent %0d rows over %0d column settings in %0d cycles;", rows_sent,
                 settings_used, cycle_count);
        $display("%0d rows judged illegal, %0d rows changed the store.", illegal_seen,
                 store_updates);
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
